/* design/devl_pkg.sv */
// Shared types, sizes and helper functions for the double-ended value list.
package devl_pkg;

   localparam int DEPTH    = 64;
   localparam int WORD_W   = 32;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 6;
   localparam int COUNT_W  = 7;
   localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int IDX_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef logic [WORD_W-1:0]  word_type;
   typedef logic [ADDR_W-1:0]  addr_type;
   typedef logic [CNT_W-1:0]   cnt_type;
   typedef logic [IDX_W-1:0]   idx_type;

   typedef enum logic [2:0] {
      KIND_PUSH_FRONT = 3'd0,
      KIND_PUSH_REAR  = 3'd1,
      KIND_POP_FRONT  = 3'd2,
      KIND_POP_REAR   = 3'd3,
      KIND_REMOVE_AT  = 3'd4,
      KIND_FIND       = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2,
      STATUS_MISS  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_POP_WAIT,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_FIND_RD,
      S_FIND_CMP,
      S_DONE
   } state_type;

   // Sign-extend the request value, then keep the stored word width.
   function automatic word_type to_word(input logic [VALUE_W-1:0] v);
      logic [63:0] e;
      e = 64'($signed(v));
      return e[WORD_W-1:0];
   endfunction

   // Sign-extend a stored word into the result field.
   function automatic logic [VALUE_W-1:0] word_out(input word_type w);
      logic [63:0] e;
      e = 64'($signed(w));
      return e[VALUE_W-1:0];
   endfunction

endpackage

/* design/double_ended_value_list_unit.sv */
// Double-ended list of signed words with push, pop, remove-at and find.
//
//  channel  | direction | tdata (low bit first)                 | tuser
//  req_     | in        | value[31:0], position[37:32], 0 pad   | kind[2:0]
//  rsp_     | out       | result_value[31:0], status[33:32],    | -
//           |           | count[40:34], 0 pad                   |
//
// One item at a time through a single-port entry memory and one shared slot adder.
// Push, empty pop, bad remove index, unknown kind: execute, then done; pop adds a read wait;
// remove-at then shifts each later entry down (read, write); find reads and compares in turn.
// Synchronous active-high reset empties the list; entry contents stay undefined.
// A finished result waits in the output register; a new item is taken once it is stored.
module double_ended_value_list_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // value[31:0], position[37:32], zero pad
   input  logic [2:0]  req_tuser,   // kind[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // result_value[31:0], status[33:32], count[40:34], zero pad
);
   import devl_pkg::*;

   state_type   state_ff, state_in;
   kind_type    kind_ff;
   word_type    word_ff;
   logic [POS_W-1:0] pos_ff;
   idx_type     idx_ff, idx_in;
   addr_type    fp_ff, fp_in;
   cnt_type     count_ff, count_in;
   logic [VALUE_W-1:0] res_ff, res_in;
   status_type  st_ff, st_in;
   word_type    rd_data_ff;
   logic        rsp_valid_ff;
   logic [VALUE_W-1:0] rsp_res_ff;
   status_type  rsp_st_ff;
   logic [COUNT_W-1:0] rsp_count_ff;

   word_type    mem [DEPTH];

   logic        req_fire;
   logic        out_free;
   logic        mem_we;
   word_type    mem_wdata;
   idx_type     offset;
   logic [IDX_W:0] slot_sum;
   addr_type    slot;
   logic [IDX_W:0] idx_p1, idx_p2, cnt_x, pos_x;
   logic        is_full, is_empty;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign out_free   = ~rsp_valid_ff | rsp_tready;

   assign idx_p1   = (IDX_W+1)'(idx_ff) + (IDX_W+1)'(1);
   assign idx_p2   = (IDX_W+1)'(idx_ff) + (IDX_W+1)'(2);
   assign cnt_x    = (IDX_W+1)'(count_ff);
   assign pos_x    = (IDX_W+1)'(pos_ff);
   assign is_full  = (cnt_x >= (IDX_W+1)'(DEPTH));
   assign is_empty = (count_ff == '0);

   // Shared slot unit: front pointer plus offset, wrapped once around the ring.
   assign slot_sum = (IDX_W+1)'(fp_ff) + (IDX_W+1)'(offset);
   assign slot = (slot_sum >= (IDX_W+1)'(DEPTH)) ?
                 ADDR_W'(slot_sum - (IDX_W+1)'(DEPTH)) : ADDR_W'(slot_sum);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:     if (req_fire) state_in = S_EXEC;
         S_EXEC: begin
            case (kind_ff)
               KIND_PUSH_FRONT, KIND_PUSH_REAR: state_in = S_DONE;
               KIND_POP_FRONT, KIND_POP_REAR:
                  state_in = is_empty ? S_DONE : S_POP_WAIT;
               KIND_REMOVE_AT:
                  state_in = (pos_x < cnt_x) ? S_POP_WAIT : S_DONE;
               KIND_FIND:
                  state_in = is_empty ? S_DONE : S_FIND_RD;
               default:     state_in = S_DONE;
            endcase
         end
         S_POP_WAIT: begin
            if (kind_ff == KIND_REMOVE_AT && idx_p1 < cnt_x) state_in = S_SHIFT_RD;
            else                                             state_in = S_DONE;
         end
         S_SHIFT_RD: state_in = S_SHIFT_WR;
         S_SHIFT_WR: state_in = (idx_p2 < cnt_x) ? S_SHIFT_RD : S_DONE;
         S_FIND_RD:  state_in = S_FIND_CMP;
         S_FIND_CMP: begin
            if (rd_data_ff == word_ff || idx_p1 >= cnt_x) state_in = S_DONE;
            else                                          state_in = S_FIND_RD;
         end
         S_DONE:     if (out_free) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // Datapath control.
   always_comb begin
      idx_in    = idx_ff;
      fp_in     = fp_ff;
      count_in  = count_ff;
      res_in    = res_ff;
      st_in     = st_ff;
      mem_we    = 1'b0;
      mem_wdata = word_ff;
      offset    = idx_ff;
      case (state_ff)
         S_IDLE: begin
            res_in = '1;
            st_in  = STATUS_MISS;
            idx_in = '0;
         end
         S_EXEC: begin
            case (kind_ff)
               KIND_PUSH_FRONT: begin
                  offset = IDX_W'(DEPTH - 1);
                  if (is_full) begin
                     st_in = STATUS_FULL;
                  end else begin
                     mem_we   = 1'b1;
                     fp_in    = slot;
                     count_in = count_ff + cnt_type'(1);
                     res_in   = '0;
                     st_in    = STATUS_OK;
                  end
               end
               KIND_PUSH_REAR: begin
                  offset = IDX_W'(count_ff);
                  if (is_full) begin
                     st_in = STATUS_FULL;
                  end else begin
                     mem_we   = 1'b1;
                     count_in = count_ff + cnt_type'(1);
                     res_in   = '0;
                     st_in    = STATUS_OK;
                  end
               end
               KIND_POP_FRONT: begin
                  offset = '0;
                  if (is_empty) st_in = STATUS_EMPTY;
               end
               KIND_POP_REAR: begin
                  offset = IDX_W'(count_ff - cnt_type'(1));
                  if (is_empty) st_in = STATUS_EMPTY;
               end
               KIND_REMOVE_AT: begin
                  offset = IDX_W'(pos_ff);
                  idx_in = IDX_W'(pos_ff);
               end
               default: ;
            endcase
         end
         S_POP_WAIT: begin
            res_in = word_out(rd_data_ff);
            st_in  = STATUS_OK;
            if (kind_ff == KIND_POP_FRONT) begin
               offset   = IDX_W'(1);
               fp_in    = slot;
               count_in = count_ff - cnt_type'(1);
            end else if (kind_ff == KIND_POP_REAR || idx_p1 >= cnt_x) begin
               count_in = count_ff - cnt_type'(1);
            end
         end
         S_SHIFT_RD: offset = IDX_W'(idx_p1);
         S_SHIFT_WR: begin
            // move the next entry down one place
            mem_we    = 1'b1;
            mem_wdata = rd_data_ff;
            idx_in    = IDX_W'(idx_p1);
            if (idx_p2 >= cnt_x) count_in = count_ff - cnt_type'(1);
         end
         S_FIND_RD: offset = idx_ff;
         S_FIND_CMP: begin
            if (rd_data_ff == word_ff) begin
               res_in = VALUE_W'(idx_ff);
               st_in  = STATUS_OK;
            end else begin
               idx_in = IDX_W'(idx_p1);
            end
         end
         default: ;
      endcase
   end

   // Entry memory: one port, registered read.
   always_ff @(posedge clock) begin
      if (mem_we) mem[slot] <= mem_wdata;
      rd_data_ff <= mem[slot];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fp_ff        <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fp_ff    <= fp_in;
         count_ff <= count_in;
         if (state_ff == S_DONE && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_tready)                rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      res_ff <= res_in;
      st_ff  <= st_in;
      if (req_fire) begin
         kind_ff <= kind_type'(req_tuser);
         word_ff <= to_word(req_tdata[VALUE_W-1:0]);
         pos_ff  <= req_tdata[VALUE_W+POS_W-1:VALUE_W];
      end
      if (state_ff == S_DONE && out_free) begin
         rsp_res_ff   <= res_ff;
         rsp_st_ff    <= st_ff;
         rsp_count_ff <= COUNT_W'(count_ff);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_count_ff, rsp_st_ff, rsp_res_ff};

endmodule

/* tb/tb.sv */
// Self-checking bench for the double-ended value list: random pushes, pops, removes and finds.
module tb;
   import devl_pkg::*;

   localparam int RANDOM_ITEMS = 1300;
   localparam int SETTLE_CYCLES = 2 * DEPTH + 20;
   localparam logic [2:0] KIND_SPARE_LO = 3'd6;
   localparam logic [2:0] KIND_SPARE_HI = 3'd7;

   typedef enum {PHASE_FILL, PHASE_DRAIN, PHASE_MIXED} phase_type;
   typedef enum {RX_OPEN, RX_BUSY, RX_SLOW, RX_HELD} rx_mode_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [1:0]         status;
      logic [COUNT_W-1:0] count;
   } list_result_type;

   class list_scoreboard;
      word_type        entries [DEPTH];
      int unsigned     head;
      int unsigned     held;
      list_result_type expected_q [$];
      int              errors;

      function new();
         head = 0;
         held = 0;
         errors = 0;
      endfunction

      function int unsigned slot(int unsigned idx);
         return (head + idx) % DEPTH;
      endfunction

      function word_type entry_at(int unsigned idx);
         return entries[slot(idx)];
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      // Apply one accepted item to the shadow list and queue its result.
      function void note_request(logic [2:0] kind, logic [VALUE_W-1:0] value,
                                 logic [POS_W-1:0] pos);
         list_result_type r;
         word_type        w;
         int unsigned     i;
         w = word_type'($signed(value));
         r.value = '1;
         r.status = STATUS_MISS;
         case (kind)
            KIND_PUSH_FRONT, KIND_PUSH_REAR: begin
               if (held == DEPTH) begin
                  r.status = STATUS_FULL;
               end else begin
                  if (kind == KIND_PUSH_FRONT) begin
                     head = (head + DEPTH - 1) % DEPTH;
                     entries[head] = w;
                  end else begin
                     entries[slot(held)] = w;
                  end
                  held++;
                  r.value = '0;
                  r.status = STATUS_OK;
               end
            end
            KIND_POP_FRONT, KIND_POP_REAR: begin
               if (held == 0) begin
                  r.status = STATUS_EMPTY;
               end else begin
                  if (kind == KIND_POP_FRONT) begin
                     r.value = VALUE_W'($signed(entries[head]));
                     head = (head + 1) % DEPTH;
                  end else begin
                     r.value = VALUE_W'($signed(entries[slot(held - 1)]));
                  end
                  held--;
                  r.status = STATUS_OK;
               end
            end
            KIND_REMOVE_AT: begin
               if (pos < held) begin
                  r.value = VALUE_W'($signed(entries[slot(pos)]));
                  for (i = pos; i + 1 < held; i++)
                     entries[slot(i)] = entries[slot(i + 1)];
                  held--;
                  r.status = STATUS_OK;
               end
            end
            KIND_FIND: begin
               for (i = 0; i < held; i++) begin
                  if (entries[slot(i)] == w) begin
                     r.value = VALUE_W'(i);
                     r.status = STATUS_OK;
                     break;
                  end
               end
            end
            default: begin
            end
         endcase
         r.count = COUNT_W'(held);
         expected_q.push_back(r);
      endfunction

      task report_mismatch(string what);
         errors++;
         if (errors <= 100)
            $display("tb: mismatch at %0t: %s", $time, what);
      endtask

      // Compare one accepted result against the oldest expectation.
      task check_response(logic [47:0] data);
         list_result_type want;
         list_result_type got;
         got.value = data[31:0];
         got.status = data[33:32];
         got.count = data[40:34];
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("unexpected item value=%h status=%0d count=%0d",
                                      got.value, got.status, got.count));
         end else begin
            want = expected_q.pop_front();
            if (got.value !== want.value)
               report_mismatch($sformatf("value %h, want %h", got.value, want.value));
            if (got.status !== want.status)
               report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.count !== want.count)
               report_mismatch($sformatf("count %0d, want %0d", got.count, want.count));
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;

   list_scoreboard sb;
   int unsigned    burst_left = 0;
   int unsigned    items_sent = 0;
   rx_mode_type    rx_mode = RX_OPEN;
   int unsigned    rx_span = 0;

   double_ended_value_list_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   initial begin
      #15_000_000;
      $display("tb: done, errors");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tdata);
   end

   // Receiver stall pattern: switch to a random mode whenever the span counter runs out.
   always @(negedge clock) begin
      if (rx_span == 0) begin
         rx_mode <= rx_mode_type'($urandom_range(0, 3));
         rx_span <= $urandom_range(20, 80);
      end else begin
         rx_span <= rx_span - 1;
      end
      case (rx_mode)
         RX_OPEN: rsp_tready <= 1'b1;
         RX_BUSY: rsp_tready <= ($urandom_range(0, 3) != 0);
         RX_SLOW: rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= (rx_span < 4);
      endcase
   end

   // Present one item at the falling edge and hold it until taken.
   task automatic send_item(logic [2:0] kind, logic [31:0] value, logic [5:0] pos);
      req_tvalid <= 1'b1;
      req_tdata <= {2'b00, pos, value};
      req_tuser <= kind;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(kind, value, pos);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic pace();
      int unsigned gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, ($urandom_range(0, 4) == 0) ? 40 : 10);
         gap = ($urandom_range(0, 3) == 0) ? 0
               : $urandom_range(1, ($urandom_range(0, 4) == 0) ? 60 : 8);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   // Hold off the sender until every outstanding result has been taken.
   task automatic drain_all();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2, 3: return 32'(int'($urandom_range(0, 6)) - 3);
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [2:0] pick_kind(phase_type ph);
      int unsigned r;
      int unsigned push_w;
      int unsigned pop_w;
      int unsigned rem_w;
      r = $urandom_range(0, 99);
      case (ph)
         PHASE_FILL: begin
            push_w = 70; pop_w = 10; rem_w = 8;
         end
         PHASE_DRAIN: begin
            push_w = 15; pop_w = 45; rem_w = 20;
         end
         default: begin
            push_w = 35; pop_w = 25; rem_w = 15;
         end
      endcase
      if (r < push_w)
         return $urandom_range(0, 1) ? KIND_PUSH_REAR : KIND_PUSH_FRONT;
      if (r < push_w + pop_w)
         return $urandom_range(0, 1) ? KIND_POP_REAR : KIND_POP_FRONT;
      if (r < push_w + pop_w + rem_w)
         return KIND_REMOVE_AT;
      if (r < 97)
         return KIND_FIND;
      return $urandom_range(0, 1) ? KIND_SPARE_HI : KIND_SPARE_LO;
   endfunction

   task automatic send_random(phase_type ph);
      logic [2:0]  kind;
      logic [31:0] value;
      logic [5:0]  pos;
      int unsigned top;
      kind = pick_kind(ph);
      value = pick_value();
      pos = 6'($urandom());
      // Aim most finds at a held word so hits land at every index.
      if (kind == KIND_FIND && sb.held != 0 && $urandom_range(0, 9) < 6)
         value = 32'($signed(sb.entry_at($urandom_range(0, sb.held - 1))));
      if (kind == KIND_REMOVE_AT && $urandom_range(0, 4) != 0) begin
         top = (sb.held < DEPTH) ? sb.held : DEPTH - 1;
         pos = 6'($urandom_range(0, top));
      end
      send_item(kind, value, pos);
      pace();
   endtask

   initial begin
      phase_type   ph;
      int unsigned span;
      sb = new();
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Empty list, unknown kinds, extreme words and edge indexes.
      send_item(KIND_POP_FRONT, 32'h0000_0000, 6'd0);
      send_item(KIND_POP_REAR, 32'hffff_ffff, 6'd63);
      send_item(KIND_REMOVE_AT, 32'h0000_0000, 6'd0);
      send_item(KIND_FIND, 32'h0000_0000, 6'd0);
      send_item(KIND_SPARE_LO, 32'h1234_5678, 6'd5);
      send_item(KIND_SPARE_HI, 32'hffff_ffff, 6'd63);
      send_item(KIND_PUSH_FRONT, 32'h7fff_ffff, 6'd63);
      send_item(KIND_PUSH_REAR, 32'h8000_0000, 6'd0);
      send_item(KIND_PUSH_FRONT, 32'hffff_ffff, 6'd42);
      send_item(KIND_PUSH_REAR, 32'h0000_0000, 6'd21);
      send_item(KIND_FIND, 32'h8000_0000, 6'd63);
      send_item(KIND_FIND, 32'h0000_0005, 6'd0);
      send_item(KIND_REMOVE_AT, 32'h0000_0000, 6'd4);
      send_item(KIND_REMOVE_AT, 32'hffff_ffff, 6'd63);
      send_item(KIND_REMOVE_AT, 32'h0000_0000, 6'd1);
      send_item(KIND_POP_REAR, 32'h0000_0000, 6'd0);
      send_item(KIND_POP_FRONT, 32'h0000_0000, 6'd0);
      send_item(KIND_POP_FRONT, 32'h0000_0000, 6'd0);
      send_item(KIND_POP_REAR, 32'h0000_0000, 6'd0);
      send_item(KIND_PUSH_REAR, 32'h5555_5555, 6'd63);
      send_item(KIND_FIND, 32'h5555_5555, 6'd0);
      send_item(KIND_REMOVE_AT, 32'haaaa_aaaa, 6'd0);
      drain_all();

      // Fill to capacity, then push into the full list.
      items_sent = 0;
      while (sb.held < DEPTH) begin
         send_item($urandom_range(0, 1) ? KIND_PUSH_REAR : KIND_PUSH_FRONT,
                   pick_value(), 6'($urandom()));
         pace();
      end
      send_item(KIND_PUSH_FRONT, pick_value(), 6'($urandom()));
      send_item(KIND_PUSH_REAR, pick_value(), 6'($urandom()));

      while (items_sent < RANDOM_ITEMS) begin
         ph = phase_type'($urandom_range(0, 2));
         span = $urandom_range(30, 120);
         repeat (span) send_random(ph);
         if ($urandom_range(0, 3) == 0)
            drain_all();
      end

      drain_all();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end
endmodule
